// ===== hw/rtl/k_strongest_bin_select_core_defines.svh =====
// Assertion macros used by the k-strongest bin select RTL.
// Expects signals named clock and reset in the scope of each use.
`ifndef K_STRONGEST_BIN_SELECT_CORE_DEFINES_SVH
`define K_STRONGEST_BIN_SELECT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KSB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KSB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ksb_pkg.sv =====
// Types and constants for the k-strongest bin select block.
// No dependencies; imported by the interfaces, the cell, the cell row and the top level.
package ksb_pkg;

   localparam int POWER_W    = 16;
   localparam int BIN_W      = 12;
   localparam int AZ_W       = 9;
   localparam int KEEP_W     = 5;
   localparam int ROWS_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_BINS = 4096;
   localparam int MAX_ROWS = 512;

   localparam logic [KEEP_W-1:0]  KEEP_COUNT_RST    = 5'd12;
   localparam logic [POWER_W-1:0] POWER_FLOOR_RST   = 16'd0;
   localparam logic [ROWS_W-1:0]  ROWS_PER_SCAN_RST = 10'd400;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_FLOOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_PER_SCAN = 2'd2;

   // operation broadcast to every cell
   typedef logic [2:0] ksb_op_type;
   localparam ksb_op_type OP_HOLD    = 3'd0;
   localparam ksb_op_type OP_INSERT  = 3'd1; // grow list by one
   localparam ksb_op_type OP_REPLACE = 3'd2; // drop weakest, insert new
   localparam ksb_op_type OP_DRAIN   = 3'd3; // drop weakest
   localparam ksb_op_type OP_POP     = 3'd4; // shift toward cell 0

   typedef struct packed {
      logic [POWER_W-1:0] power;
      logic [BIN_W-1:0]   bin;
   } ksb_entry_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic          occ;   // holds a kept bin
      logic          gt;    // stronger than the incoming bin
      logic          eq;    // equal to the weakest power (cell 0)
      ksb_entry_type entry;
   } ksb_link_type;

endpackage

// ===== hw/rtl/ksb_if.sv =====
// Valid/ready stream interfaces for bin beats in and selected-bin beats out.
// Depends on ksb_pkg for field widths.
interface ksb_req_if import ksb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POWER_W-1:0] power;
   logic               row_end;

   modport source (output valid, output power, output row_end, input ready);
   modport sink   (input valid, input power, input row_end, output ready);
endinterface

interface ksb_rsp_if import ksb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [AZ_W-1:0]    azimuth;
   logic [BIN_W-1:0]   range_bin;
   logic [POWER_W-1:0] bin_power;
   logic               last_of_row;

   modport source (output valid, output azimuth, output range_bin, output bin_power,
                   output last_of_row, input ready);
   modport sink   (input valid, input azimuth, input range_bin, input bin_power,
                   input last_of_row, output ready);
endinterface

// ===== hw/rtl/k_strongest_bin_select_core.sv =====
// k-strongest range bin selection per azimuth row.
// req_chan takes one range-bin beat (power, row_end) per cycle while ready is high.
// Bins are inserted into a sorted row of MAX_KEEP cells in the cycle they are taken,
// so a row streams at one bin per cycle. The beat with row_end set closes the row.
// After it, the cell row shifts toward cell 0 one entry per cycle: entries at or
// below power_floor are dropped silently, the rest go out on rsp_chan in ascending
// power order (ties in arrival order), the last one flagged last_of_row.
// The row_end beat sets the drain flag; each result then passes through the output
// register. The drain pops every kept bin and waits while the receiver stalls.
// req_chan.ready is low for that drain.
// rsp_chan has a single output register: a stalled receiver holds the drain,
// and once the final result sits in the register the next row can start.
// Lowering keep_count mid-row drops one weakest bin per cycle (ready low) once the
// next bin is offered, before it is taken. csr writes land at once; write only while
// idle.
// Synchronous reset clears the counters, the kept count and the output valid, and
// sets the csr registers to their defaults; no clearing pass is needed.
`include "k_strongest_bin_select_core_defines.svh"

module k_strongest_bin_select_core import ksb_pkg::*; #(
   parameter int MAX_KEEP = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   ksb_req_if.sink               req_chan,
   ksb_rsp_if.source             rsp_chan
);

   localparam int FILL_W = $clog2(MAX_KEEP + 1);
   localparam int CMP_W  = (FILL_W > KEEP_W) ? FILL_W : KEEP_W;

   // csr registers
   logic [KEEP_W-1:0]  keep_count_ff;
   logic [POWER_W-1:0] power_floor_ff;
   logic [ROWS_W-1:0]  rows_per_scan_ff;

   // row state
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              emit_ff, emit_in;
   logic [BIN_W-1:0]  bin_ff, bin_in;
   logic [AZ_W-1:0]   row_ff, row_in;
   logic [AZ_W-1:0]   emit_az_ff;

   // output register
   logic              rsp_valid_ff;
   ksb_entry_type     rsp_entry_ff;
   logic              rsp_last_ff;
   logic [AZ_W-1:0]   rsp_az_ff;

   logic [CMP_W-1:0]  keep_ext, keff_ext, fill_ext;
   logic [ROWS_W-1:0] rows_eff, row_inc;
   logic              draining, req_fire, out_free, head_above, load_out;
   ksb_op_type        op;
   ksb_entry_type     new_entry, head;

   // effective keep count: zero acts as one, capped at the cell count
   assign keep_ext = CMP_W'(keep_count_ff);
   assign fill_ext = CMP_W'(fill_ff);
   always_comb begin
      priority if (keep_ext == '0) begin
         keff_ext = CMP_W'(1);
      end else if (keep_ext > CMP_W'(MAX_KEEP)) begin
         keff_ext = CMP_W'(MAX_KEEP);
      end else begin
         keff_ext = keep_ext;
      end
   end

   assign draining = fill_ext > keff_ext;

   assign req_chan.ready = !emit_ff && !draining;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign new_entry.power = req_chan.power;
   assign new_entry.bin   = bin_ff;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign head_above = head.power > power_floor_ff;

   // one chain operation per cycle
   always_comb begin
      op       = OP_HOLD;
      fill_in  = fill_ff;
      load_out = 1'b0;
      priority if (req_fire) begin
         if (fill_ext < keff_ext) begin
            op      = OP_INSERT;
            fill_in = fill_ff + FILL_W'(1);
         end else if (req_chan.power > head.power) begin
            // full: weakest out, new bin in; an equal bin loses to the kept one
            op = OP_REPLACE;
         end
      end else if (emit_ff) begin
         if (!head_above || out_free) begin
            op       = OP_POP;
            fill_in  = fill_ff - FILL_W'(1);
            load_out = head_above;
         end
      end else if (draining && req_chan.valid) begin
         // trim only once the next bin waits; a keep_count raised again first keeps all
         op      = OP_DRAIN;
         fill_in = fill_ff - FILL_W'(1);
      end else begin
         op = OP_HOLD;
      end
   end

   always_comb begin
      emit_in = emit_ff;
      if (req_fire && req_chan.row_end) begin
         emit_in = 1'b1;
      end else if ((op == OP_POP) && (fill_ff == FILL_W'(1))) begin
         emit_in = 1'b0;
      end
   end

   // bin and azimuth counters
   always_comb begin
      priority if (rows_per_scan_ff == '0) begin
         rows_eff = ROWS_W'(1);
      end else if (rows_per_scan_ff > ROWS_W'(MAX_ROWS)) begin
         rows_eff = ROWS_W'(MAX_ROWS);
      end else begin
         rows_eff = rows_per_scan_ff;
      end
   end

   assign row_inc = ROWS_W'(row_ff) + ROWS_W'(1);

   always_comb begin
      bin_in = bin_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (req_chan.row_end) begin
            bin_in = '0;
            row_in = (row_inc >= rows_eff) ? '0 : row_inc[AZ_W-1:0];
         end else begin
            bin_in = (bin_ff == BIN_W'(MAX_BINS - 1)) ? '0 : bin_ff + BIN_W'(1);
         end
      end
   end

   ksb_chain #(
      .MAX_KEEP (MAX_KEEP)
   ) u_chain (
      .clock     (clock),
      .op        (op),
      .new_entry (new_entry),
      .fill      (fill_ff),
      .head      (head)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff    <= KEEP_COUNT_RST;
         power_floor_ff   <= POWER_FLOOR_RST;
         rows_per_scan_ff <= ROWS_PER_SCAN_RST;
         fill_ff          <= '0;
         emit_ff          <= 1'b0;
         bin_ff           <= '0;
         row_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_KEEP_COUNT:    keep_count_ff    <= csr_wdata[KEEP_W-1:0];
               CSR_POWER_FLOOR:   power_floor_ff   <= csr_wdata[POWER_W-1:0];
               CSR_ROWS_PER_SCAN: rows_per_scan_ff <= csr_wdata[ROWS_W-1:0];
               default: ;
            endcase
         end
         fill_ff <= fill_in;
         emit_ff <= emit_in;
         bin_ff  <= bin_in;
         row_ff  <= row_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire && req_chan.row_end) begin
         emit_az_ff <= row_ff;
      end
      if (load_out) begin
         rsp_entry_ff <= head;
         rsp_last_ff  <= (fill_ff == FILL_W'(1));
         rsp_az_ff    <= emit_az_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.azimuth     = rsp_az_ff;
   assign rsp_chan.range_bin   = rsp_entry_ff.bin;
   assign rsp_chan.bin_power   = rsp_entry_ff.power;
   assign rsp_chan.last_of_row = rsp_last_ff;

   `KSB_ASSERT_NEXT(a_row_end_drains, req_fire && req_chan.row_end,
      emit_ff && (fill_ff != '0), "row end did not start the drain")
   `KSB_ASSERT_SAME(a_drain_nonempty, emit_ff, fill_ff != '0,
      "drain active with no kept bins")
   `KSB_ASSERT_NEXT(a_last_closes, load_out && (fill_ff == FILL_W'(1)),
      !emit_ff && rsp_chan.valid && rsp_chan.last_of_row, "final result did not close the row")
   `KSB_ASSERT_NEXT(a_stall_holds, emit_ff && head_above && !out_free,
      $stable(fill_ff), "cell row moved under a stalled output")

endmodule

// ===== hw/rtl/ksb_cell.sv =====
// One slot of the sorted kept-bin list.
// Depends on ksb_pkg; instantiated by ksb_chain.
module ksb_cell import ksb_pkg::*; (
   input  logic          clock,
   input  ksb_op_type    op,
   input  ksb_entry_type new_entry,
   input  logic [POWER_W-1:0] min_power,
   input  logic          occ,
   input  ksb_link_type  lo,
   input  ksb_link_type  hi,
   output ksb_link_type  link
);

   ksb_entry_type entry_ff;
   ksb_entry_type entry_in;

   assign link.occ   = occ;
   assign link.gt    = occ && (entry_ff.power > new_entry.power);
   assign link.eq    = occ && (entry_ff.power == min_power);
   assign link.entry = entry_ff;

   // list order: ascending power, equal powers in arrival order
   always_comb begin
      entry_in = entry_ff;
      unique case (op)
         OP_INSERT: begin
            if (lo.gt) begin
               entry_in = lo.entry;
            end else if (link.gt || (!occ && lo.occ)) begin
               entry_in = new_entry;
            end
         end
         OP_REPLACE: begin
            // slots from the dropped one up to the insert point move down
            if (occ && !link.gt && (hi.gt || !hi.occ)) begin
               entry_in = new_entry;
            end else if (occ && !(link.eq && hi.eq) && hi.occ && !hi.gt) begin
               entry_in = hi.entry;
            end
         end
         OP_DRAIN: begin
            if (occ && !(link.eq && hi.eq)) begin
               entry_in = hi.entry;
            end
         end
         OP_POP: begin
            entry_in = hi.entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hw/rtl/ksb_chain.sv =====
// Row of kept-bin cells; each cell trades entries with its two neighbors.
// Depends on ksb_pkg and ksb_cell.
module ksb_chain import ksb_pkg::*; #(
   parameter int MAX_KEEP = 16
) (
   input  logic          clock,
   input  ksb_op_type    op,
   input  ksb_entry_type new_entry,
   input  logic [$clog2(MAX_KEEP+1)-1:0] fill,
   output ksb_entry_type head
);

   localparam int FILL_W = $clog2(MAX_KEEP + 1);

   // below cell 0 sits a virtual occupied, weaker slot; above the top, nothing
   localparam ksb_link_type LO_EDGE = '{occ: 1'b1, gt: 1'b0, eq: 1'b0, entry: '0};
   localparam ksb_link_type HI_EDGE = '{occ: 1'b0, gt: 1'b0, eq: 1'b0, entry: '0};

   ksb_link_type links [MAX_KEEP];
   logic [POWER_W-1:0] min_power;

   assign min_power = links[0].entry.power;
   assign head      = links[0].entry;

   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      ksb_link_type lo;
      ksb_link_type hi;
      logic         occ;

      assign occ = (FILL_W'(i) < fill);

      if (i == 0) begin : g_lo_edge
         assign lo = LO_EDGE;
      end else begin : g_lo_link
         assign lo = links[i-1];
      end

      if (i == MAX_KEEP - 1) begin : g_hi_edge
         assign hi = HI_EDGE;
      end else begin : g_hi_link
         assign hi = links[i+1];
      end

      ksb_cell u_cell (
         .clock     (clock),
         .op        (op),
         .new_entry (new_entry),
         .min_power (min_power),
         .occ       (occ),
         .lo        (lo),
         .hi        (hi),
         .link      (links[i])
      );
   end

endmodule
